// ----- rtl/encoder_alignment_sequencer_top_assert.svh -----
// Assertion macros used by the checker of the alignment sequencer.
`ifndef ENCODER_ALIGNMENT_SEQUENCER_TOP_ASSERT_SVH
`define ENCODER_ALIGNMENT_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define EAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define EAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/eas_pkg.sv -----
// Package with the types, codes and constant tables of the alignment sequencer.
package eas_pkg;

    localparam int NUM_SWINGS = 10;
    localparam int SWING_W    = $clog2(NUM_SWINGS + 1);
    localparam int TAB_DEPTH  = 1 << SWING_W;
    localparam int SWING_DEN  = 10 * NUM_SWINGS;

    localparam int MAG_W   = 16;
    localparam int DELAY_W = 10;
    localparam int VOLT_W  = 17;
    localparam int TRIG_W  = 16;
    localparam int CFG_W   = 16;

    localparam logic [DELAY_W-1:0] STEP_DELAY_RESET = DELAY_W'(100);

    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [DELAY_W-1:0]       delay_t;
    typedef logic [SWING_W-1:0]       swing_t;
    typedef logic signed [VOLT_W-1:0] volt_t;
    typedef logic [TRIG_W-1:0]        trig_t;
    typedef trig_t                    trig_tab_t [0:TAB_DEPTH-1];

    // Configuration register indexes.
    localparam logic CFG_DRIVE_MAGNITUDE = 1'b0;
    localparam logic CFG_STEP_DELAY      = 1'b1;

    // Loop status codes.
    localparam logic [1:0] STATUS_BUSY  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    // Sequencer phases.
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_SWING   = 3'd1;
    localparam logic [2:0] PH_WAIT    = 3'd2;
    localparam logic [2:0] PH_CAPTURE = 3'd3;
    localparam logic [2:0] PH_ZERO    = 3'd4;
    localparam logic [2:0] PH_REPORT  = 3'd5;

    // Drive kinds handed from the sequencer to the voltage stage.
    localparam logic [1:0] DRV_NONE  = 2'd0;
    localparam logic [1:0] DRV_SWING = 2'd1;
    localparam logic [1:0] DRV_HOLD  = 2'd2;
    localparam logic [1:0] DRV_ZERO  = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        swing_t     k;
        logic [1:0] status;
        logic       capture;
    } drive_cmd_t;

    // Q1.15 cos or sin of the swing angle magnitude, from truncated Taylor terms in Q0.30.
    function automatic trig_tab_t build_trig_tab(input logic want_sin);
        trig_tab_t       tab;
        longint unsigned th;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned x3;
        longint unsigned x4;
        longint unsigned x5;
        longint unsigned c30;
        longint unsigned s30;
        longint unsigned c15;
        longint unsigned s15;
        for (int k = 0; k < TAB_DEPTH; k++)
        begin
            if (k < NUM_SWINGS)
            begin
                th  = 64'(65536 * (NUM_SWINGS - k) + 5 * NUM_SWINGS) / SWING_DEN;
                x   = th << 15;
                x2  = th * th;
                x3  = (x2 * th) >> 15;
                x4  = (x2 * x2) >> 30;
                x5  = (x4 * th) >> 15;
                c30 = (64'd1 << 30) - x2 / 2 + x4 / 24;
                s30 = x - x3 / 6 + x5 / 120;
                c15 = (c30 + 64'd16384) >> 15;
                s15 = (s30 + 64'd16384) >> 15;
                if (c15 > 64'd32767)
                begin
                    c15 = 64'd32767;
                end
                tab[k] = want_sin ? TRIG_W'(s15) : TRIG_W'(c15);
            end
            else
            begin
                tab[k] = '0;
            end
        end
        return tab;
    endfunction

    localparam trig_tab_t COS_TAB = build_trig_tab(1'b0);
    localparam trig_tab_t SIN_TAB = build_trig_tab(1'b1);

endpackage

// ----- rtl/eas_if.sv -----
// Handshake channels of the alignment sequencer: one for calls, one for results.
interface eas_in_if;
    logic valid;
    logic ready;
    logic ms_elapsed;
    logic zero_ok;

    modport source (output valid, output ms_elapsed, output zero_ok, input ready);
    modport sink   (input valid, input ms_elapsed, input zero_ok, output ready);
endinterface

interface eas_out_if;
    logic           valid;
    logic           ready;
    logic [1:0]     loop_status;
    logic           drive_update;
    eas_pkg::volt_t volt_alpha;
    eas_pkg::volt_t volt_beta;
    logic           capture_zero;

    modport source (output valid, output loop_status, output drive_update,
                    output volt_alpha, output volt_beta, output capture_zero,
                    input ready);
    modport sink   (input valid, input loop_status, input drive_update,
                    input volt_alpha, input volt_beta, input capture_zero,
                    output ready);
endinterface

// ----- rtl/eas_ctrl.sv -----
// Step sequencer: countdown, phase machine and registered drive command.
module eas_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    eas_in_if.sink              in_ch,
    input  eas_pkg::delay_t     step_delay,
    output logic                cmd_valid,
    output eas_pkg::drive_cmd_t cmd,
    input  logic                cmd_ready
);

    logic [2:0]          phase_reg;
    logic [2:0]          phase_next;
    eas_pkg::swing_t     swing_reg;
    eas_pkg::swing_t     swing_next;
    eas_pkg::delay_t     delay_reg;
    eas_pkg::delay_t     delay_next;
    eas_pkg::delay_t     delay_dec;
    logic                cmd_valid_reg;
    eas_pkg::drive_cmd_t cmd_reg;
    eas_pkg::drive_cmd_t cmd_next;
    logic                accept;

    assign in_ch.ready = !cmd_valid_reg || cmd_ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign cmd_valid   = cmd_valid_reg;
    assign cmd         = cmd_reg;

    always_comb
    begin
        delay_dec = (in_ch.ms_elapsed && delay_reg != '0) ? delay_reg - 1'b1 : delay_reg;

        phase_next       = phase_reg;
        swing_next       = swing_reg;
        delay_next       = delay_dec;
        cmd_next.kind    = eas_pkg::DRV_NONE;
        cmd_next.k       = swing_reg;
        cmd_next.status  = eas_pkg::STATUS_BUSY;
        cmd_next.capture = 1'b0;

        if (delay_dec == '0)
        begin
            unique case (phase_reg)
                eas_pkg::PH_IDLE:
                begin
                    swing_next = '0;
                    phase_next = eas_pkg::PH_SWING;
                    delay_next = step_delay;
                end
                eas_pkg::PH_SWING:
                begin
                    if (swing_reg < eas_pkg::SWING_W'(eas_pkg::NUM_SWINGS))
                    begin
                        cmd_next.kind = eas_pkg::DRV_SWING;
                        swing_next    = swing_reg + 1'b1;
                    end
                    else
                    begin
                        // Past the last swing: hold angle zero at full magnitude.
                        cmd_next.kind = eas_pkg::DRV_HOLD;
                        swing_next    = '0;
                        phase_next    = eas_pkg::PH_WAIT;
                    end
                    delay_next = step_delay;
                end
                eas_pkg::PH_WAIT:
                begin
                    phase_next = eas_pkg::PH_CAPTURE;
                    delay_next = step_delay;
                end
                eas_pkg::PH_CAPTURE:
                begin
                    cmd_next.capture = 1'b1;
                    if (!in_ch.zero_ok)
                    begin
                        // The countdown stays at zero so the restart fires at once.
                        cmd_next.kind   = eas_pkg::DRV_ZERO;
                        cmd_next.status = eas_pkg::STATUS_ERROR;
                        phase_next      = eas_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = eas_pkg::PH_ZERO;
                        delay_next = step_delay;
                    end
                end
                eas_pkg::PH_ZERO:
                begin
                    cmd_next.kind = eas_pkg::DRV_ZERO;
                    phase_next    = eas_pkg::PH_REPORT;
                    delay_next    = step_delay;
                end
                default:
                begin
                    cmd_next.status = eas_pkg::STATUS_DONE;
                    phase_next      = eas_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= eas_pkg::PH_IDLE;
            swing_reg     <= '0;
            delay_reg     <= '0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                swing_reg <= swing_next;
                delay_reg <= delay_next;
            end
            if (in_ch.ready)
            begin
                cmd_valid_reg <= in_ch.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ----- rtl/eas_drive.sv -----
// Voltage stage: scales the table cos/sin by the drive magnitude into the result register.
module eas_drive
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  eas_pkg::drive_cmd_t cmd,
    output logic                cmd_ready,
    input  eas_pkg::mag_t       magnitude,
    eas_out_if.source           out_ch
);

    logic                       out_valid_reg;
    logic [1:0]                 status_reg;
    logic                       update_reg;
    eas_pkg::volt_t             alpha_reg;
    eas_pkg::volt_t             alpha_next;
    eas_pkg::volt_t             beta_reg;
    eas_pkg::volt_t             beta_next;
    logic                       capture_reg;
    logic [2*eas_pkg::MAG_W-1:0] prod_cos;
    logic [2*eas_pkg::MAG_W-1:0] prod_sin;
    logic [2*eas_pkg::MAG_W:0]   round_cos;
    logic [2*eas_pkg::MAG_W:0]   round_sin;
    eas_pkg::volt_t             swing_alpha;
    eas_pkg::volt_t             swing_beta;
    logic                       take;

    assign cmd_ready = !out_valid_reg || out_ch.ready;
    assign take      = cmd_valid && cmd_ready;

    always_comb
    begin
        prod_cos    = (2*eas_pkg::MAG_W)'(magnitude) * (2*eas_pkg::MAG_W)'(eas_pkg::COS_TAB[cmd.k]);
        prod_sin    = (2*eas_pkg::MAG_W)'(magnitude) * (2*eas_pkg::MAG_W)'(eas_pkg::SIN_TAB[cmd.k]);
        round_cos   = {1'b0, prod_cos} + (2*eas_pkg::MAG_W+1)'(16384);
        round_sin   = {1'b0, prod_sin} + (2*eas_pkg::MAG_W+1)'(16384);
        swing_alpha = eas_pkg::volt_t'(round_cos[15 +: eas_pkg::VOLT_W]);
        swing_beta  = eas_pkg::volt_t'(round_sin[15 +: eas_pkg::VOLT_W]);

        unique case (cmd.kind)
            eas_pkg::DRV_SWING:
            begin
                alpha_next = swing_alpha;
                // Odd swings sit on the negative side of angle zero.
                beta_next  = cmd.k[0] ? -swing_beta : swing_beta;
            end
            eas_pkg::DRV_HOLD:
            begin
                alpha_next = eas_pkg::volt_t'({1'b0, magnitude});
                beta_next  = '0;
            end
            default:
            begin
                alpha_next = '0;
                beta_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            out_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg  <= cmd.status;
            update_reg  <= (cmd.kind != eas_pkg::DRV_NONE);
            alpha_reg   <= alpha_next;
            beta_reg    <= beta_next;
            capture_reg <= cmd.capture;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.loop_status  = status_reg;
    assign out_ch.drive_update = update_reg;
    assign out_ch.volt_alpha   = alpha_reg;
    assign out_ch.volt_beta    = beta_reg;
    assign out_ch.capture_zero = capture_reg;

endmodule

// ----- rtl/encoder_alignment_sequencer_top.sv -----
// Top level of the encoder alignment sequencer: configuration registers and the two stages.
// One call is accepted per clock cycle while the output is not stalled, and its result is
// registered first as the sequencer's drive command, then as the voltages after the magnitude
// multiply. Each call with ms_elapsed set advances the millisecond countdown; when it reaches
// zero the sequence steps through the decaying swings, the hold at angle zero, the zero
// capture strobe, zero volts and the completion report. A failed capture reports an error
// and restarts. Register 0 is the drive magnitude in mV, register 1 the step delay in ms;
// write them only while no call is in flight.
module encoder_alignment_sequencer_top
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [eas_pkg::CFG_W-1:0] cfg_data,
    eas_in_if.sink                  in_ch,
    eas_out_if.source               out_ch
);

    eas_pkg::mag_t       magnitude_reg;
    eas_pkg::delay_t     step_delay_reg;
    logic                cmd_valid;
    logic                cmd_ready;
    eas_pkg::drive_cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magnitude_reg  <= '0;
            step_delay_reg <= eas_pkg::STEP_DELAY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                eas_pkg::CFG_DRIVE_MAGNITUDE: magnitude_reg  <= cfg_data;
                eas_pkg::CFG_STEP_DELAY:      step_delay_reg <= cfg_data[eas_pkg::DELAY_W-1:0];
                default:                      magnitude_reg  <= magnitude_reg;
            endcase
        end
    end

    eas_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .step_delay (step_delay_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_ready  (cmd_ready)
    );

    eas_drive u_drive
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .magnitude (magnitude_reg),
        .out_ch    (out_ch)
    );

endmodule

// ----- rtl/eas_checker.sv -----
// Port-level checker for the alignment sequencer and its bind to the top level.
`include "encoder_alignment_sequencer_top_assert.svh"

module eas_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_ready,
    input logic [1:0]     out_status,
    input logic           out_update,
    input eas_pkg::volt_t out_alpha,
    input eas_pkg::volt_t out_beta,
    input logic           out_capture
);

    logic stalled;
    logic no_update;
    logic volts_zero;
    logic is_error;
    logic is_done;
    logic err_shape;
    logic done_shape;

    assign stalled    = out_valid && !out_ready;
    assign no_update  = out_valid && !out_update;
    assign volts_zero = (out_alpha == '0) && (out_beta == '0);
    assign is_error   = out_valid && (out_status == eas_pkg::STATUS_ERROR);
    assign is_done    = out_valid && (out_status == eas_pkg::STATUS_DONE);
    assign err_shape  = out_capture && out_update && volts_zero;
    assign done_shape = !out_capture && !out_update;

    // A result that is not taken stays offered.
    `EAS_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid, "stalled result dropped")

    // Without a drive update the voltage commands are zero.
    `EAS_ASSERT_NOW(a_idle_zero, clk, rst_n, no_update, volts_zero, "volts without update")

    // An error result carries the capture strobe and a drive update of zero volts.
    `EAS_ASSERT_NOW(a_error_form, clk, rst_n, is_error, err_shape, "malformed error result")

    // Completion is reported on a step that neither drives nor captures.
    `EAS_ASSERT_NOW(a_done_form, clk, rst_n, is_done, done_shape, "malformed completion result")

endmodule

bind encoder_alignment_sequencer_top eas_checker u_eas_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.loop_status),
    .out_update  (out_ch.drive_update),
    .out_alpha   (out_ch.volt_alpha),
    .out_beta    (out_ch.volt_beta),
    .out_capture (out_ch.capture_zero)
);

// ----- verif/tb_encoder_alignment_sequencer_top.sv -----
// Testbench for the encoder alignment sequencer: directed and random calls checked against a cycle-free predictor.
module tb_encoder_alignment_sequencer_top;
    import eas_pkg::*;

    typedef struct packed
    {
        logic ms_elapsed;
        logic zero_ok;
    } call_t;

    typedef struct packed
    {
        logic [1:0] loop_status;
        logic       drive_update;
        volt_t      volt_alpha;
        volt_t      volt_beta;
        logic       capture_zero;
    } align_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    eas_in_if  in_ch ();
    eas_out_if out_ch ();

    encoder_alignment_sequencer_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predictor copy of the registers and the sequencer state.
    mag_t       seq_mag        = '0;
    delay_t     seq_step_delay = STEP_DELAY_RESET;
    logic [2:0] seq_phase      = PH_IDLE;
    swing_t     seq_swing      = '0;
    delay_t     seq_delay_left = '0;

    call_t         pending_calls [$];
    align_result_t expected_results [$];

    int n_fail     = 0;
    int n_results  = 0;
    int n_done     = 0;
    int n_error    = 0;
    int n_settings = 0;
    int send_gap;
    int recv_stall;
    bit send_calm;
    bit recv_calm;

    always #5 clk = ~clk;

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 2);
        end
        else if (r < 95)
        begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic volt_t scale_by_mag(input mag_t m, input longint unsigned q15);
        longint unsigned p;
        p = (64'(m) * q15 + 64'd16384) >> 15;
        return volt_t'(p);
    endfunction

    // Alpha and beta of swing k: Taylor cos/sin of the angle magnitude, scaled by the magnitude.
    task automatic swing_drive(input swing_t k, output volt_t alpha, output volt_t beta);
        longint unsigned th;
        longint unsigned p2;
        longint unsigned p3;
        longint unsigned p4;
        longint unsigned p5;
        longint unsigned cos15;
        longint unsigned sin15;
        th = (64'd65536 * 64'(NUM_SWINGS - int'(k)) + 64'd5 * NUM_SWINGS)
             / (64'd10 * NUM_SWINGS);
        p2 = th * th;
        p3 = (p2 * th) >> 15;
        p4 = (p2 * p2) >> 30;
        p5 = (p4 * th) >> 15;
        cos15 = ((64'd1 << 30) - p2 / 2 + p4 / 24 + 64'd16384) >> 15;
        sin15 = ((th << 15) - p3 / 6 + p5 / 120 + 64'd16384) >> 15;
        if (cos15 > 64'd32767)
        begin
            cos15 = 64'd32767;
        end
        alpha = scale_by_mag(seq_mag, cos15);
        beta  = scale_by_mag(seq_mag, sin15);
        if (k[0])
        begin
            beta = -beta;
        end
    endtask

    task automatic advance_sequencer(input logic tick, input logic capture_ok);
        align_result_t r;
        r = '0;
        if (tick && seq_delay_left != '0)
        begin
            seq_delay_left = seq_delay_left - 1'b1;
        end
        if (seq_delay_left == '0)
        begin
            case (seq_phase)
                PH_IDLE:
                begin
                    seq_swing      = '0;
                    seq_phase      = PH_SWING;
                    seq_delay_left = seq_step_delay;
                end
                PH_SWING:
                begin
                    r.drive_update = 1'b1;
                    if (seq_swing < NUM_SWINGS)
                    begin
                        swing_drive(seq_swing, r.volt_alpha, r.volt_beta);
                        seq_swing = seq_swing + 1'b1;
                    end
                    else
                    begin
                        // Hold at angle zero: full magnitude on alpha.
                        r.volt_alpha = volt_t'({1'b0, seq_mag});
                        seq_swing    = '0;
                        seq_phase    = PH_WAIT;
                    end
                    seq_delay_left = seq_step_delay;
                end
                PH_WAIT:
                begin
                    seq_phase      = PH_CAPTURE;
                    seq_delay_left = seq_step_delay;
                end
                PH_CAPTURE:
                begin
                    r.capture_zero = 1'b1;
                    if (!capture_ok)
                    begin
                        r.drive_update = 1'b1;
                        r.loop_status  = STATUS_ERROR;
                        seq_phase      = PH_IDLE;
                    end
                    else
                    begin
                        seq_phase      = PH_ZERO;
                        seq_delay_left = seq_step_delay;
                    end
                end
                PH_ZERO:
                begin
                    r.drive_update = 1'b1;
                    seq_phase      = PH_REPORT;
                    seq_delay_left = seq_step_delay;
                end
                default:
                begin
                    r.loop_status = STATUS_DONE;
                    seq_phase     = PH_IDLE;
                end
            endcase
        end
        expected_results.push_back(r);
    endtask

    // Call driver: pops pending calls, inserts random gaps after some of them.
    always @(posedge clk)
    begin
        call_t c;
        bit    busy;
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.ms_elapsed <= 1'b0;
            in_ch.zero_ok    <= 1'b0;
            send_gap = 0;
            send_calm = 1'b0;
        end
        else
        begin
            busy = in_ch.valid;
            if (in_ch.valid && in_ch.ready)
            begin
                advance_sequencer(in_ch.ms_elapsed, in_ch.zero_ok);
                busy = 1'b0;
            end
            if ($urandom_range(0, 199) == 0)
            begin
                send_calm = !send_calm;
            end
            if (!busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_calls.size() != 0)
                begin
                    c = pending_calls.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.ms_elapsed <= c.ms_elapsed;
                    in_ch.zero_ok    <= c.zero_ok;
                    if (!send_calm && $urandom_range(0, 99) < 35)
                    begin
                        send_gap = pick_pause();
                    end
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each transfer with the oldest expectation, stalls at random.
    always @(posedge clk)
    begin
        align_result_t got;
        align_result_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_stall = 0;
            recv_calm = 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.loop_status  = out_ch.loop_status;
                got.drive_update = out_ch.drive_update;
                got.volt_alpha   = out_ch.volt_alpha;
                got.volt_beta    = out_ch.volt_beta;
                got.capture_zero = out_ch.capture_zero;
                if (expected_results.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: result with no call outstanding: expected none, got %h",
                             $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    n_results++;
                    if (want.loop_status == STATUS_DONE)
                    begin
                        n_done++;
                    end
                    if (want.loop_status == STATUS_ERROR)
                    begin
                        n_error++;
                    end
                    if (got !== want)
                    begin
                        n_fail++;
                        // Fields in order: status, update, alpha, beta, capture.
                        $display(
                            "%0t: mismatch: expected %0d %b %0d %0d %b, got %0d %b %0d %0d %b",
                            $time, want.loop_status, want.drive_update,
                            $signed(want.volt_alpha), $signed(want.volt_beta),
                            want.capture_zero, got.loop_status, got.drive_update,
                            $signed(got.volt_alpha), $signed(got.volt_beta),
                            got.capture_zero);
                    end
                end
            end
            if ($urandom_range(0, 199) == 0)
            begin
                recv_calm = !recv_calm;
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!recv_calm && $urandom_range(0, 99) < 25)
                begin
                    recv_stall = pick_pause();
                end
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_DRIVE_MAGNITUDE)
        begin
            seq_mag = data[MAG_W-1:0];
        end
        else
        begin
            seq_step_delay = data[DELAY_W-1:0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Returns once every call has been sent and every result has come back.
    task automatic wait_for_drain();
        do
        begin
            @(negedge clk);
        end
        while (pending_calls.size() != 0 || in_ch.valid || expected_results.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic queue_random_calls(input int count);
        call_t c;
        @(negedge clk);
        repeat (count)
        begin
            c.ms_elapsed = ($urandom_range(0, 99) < 85);
            c.zero_ok    = ($urandom_range(0, 99) < 75);
            pending_calls.push_back(c);
        end
    endtask

    function automatic logic [CFG_W-1:0] random_delay_word();
        int          r;
        logic [5:0]  upper;
        delay_t      d;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            d = delay_t'($urandom_range(0, 3));
        end
        else if (r < 9)
        begin
            d = delay_t'($urandom_range(4, 12));
        end
        else
        begin
            d = '0;
        end
        // Bits above the register width are ignored by the block.
        upper = $urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'd0;
        return {upper, d};
    endfunction

    initial
    begin
        call_t c;
        logic [5:0] tick_pattern;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_DRIVE_MAGNITUDE;
        cfg_data         = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // One full sequence at maximum magnitude with no wait between steps.
        write_reg(CFG_DRIVE_MAGNITUDE, 16'hFFFF);
        write_reg(CFG_STEP_DELAY, 16'd0);
        n_settings++;
        @(negedge clk);
        for (int i = 0; i < 16; i++)
        begin
            c.ms_elapsed = i[0];
            c.zero_ok    = 1'b1;
            pending_calls.push_back(c);
        end
        wait_for_drain();

        // Zero magnitude and a one tick delay: calls without a tick must hold the step.
        write_reg(CFG_DRIVE_MAGNITUDE, 16'd0);
        write_reg(CFG_STEP_DELAY, 16'd1);
        n_settings++;
        tick_pattern = 6'b011010;
        @(negedge clk);
        for (int i = 0; i < 6; i++)
        begin
            c.ms_elapsed = tick_pattern[i];
            c.zero_ok    = 1'($urandom_range(0, 1));
            pending_calls.push_back(c);
        end
        wait_for_drain();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(CFG_DRIVE_MAGNITUDE, 16'd0);
                    write_reg(CFG_STEP_DELAY, 16'd0);
                end
                1:
                begin
                    write_reg(CFG_STEP_DELAY, 16'd1);
                    write_reg(CFG_DRIVE_MAGNITUDE, 16'hFFFF);
                end
                2:
                begin
                    write_reg(CFG_DRIVE_MAGNITUDE, 16'd1);
                    write_reg(CFG_STEP_DELAY, random_delay_word());
                end
                default:
                begin
                    write_reg(CFG_DRIVE_MAGNITUDE, CFG_W'($urandom_range(0, 65535)));
                    write_reg(CFG_STEP_DELAY, random_delay_word());
                end
            endcase
            n_settings++;
            if (p == 3)
            begin
                // The sender holds off mid-run until every result is back.
                queue_random_calls(45);
                wait_for_drain();
                queue_random_calls(45);
            end
            else
            begin
                queue_random_calls(90);
            end
            wait_for_drain();
        end

        // Longest step delay, with every data bit set.
        write_reg(CFG_DRIVE_MAGNITUDE, CFG_W'($urandom_range(0, 65535)));
        write_reg(CFG_STEP_DELAY, 16'hFFFF);
        n_settings++;
        queue_random_calls(60);
        wait_for_drain();

        repeat (5) @(posedge clk);
        $display("%0d results checked over %0d register settings;", n_results, n_settings);
        $display("%0d alignments completed and %0d capture failures seen.", n_done, n_error);
        if (n_fail == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule
